[sv/mpfb_pkg.sv]
// Package for the page framebuffer draw engine: command codes, states, font ROM.
package mpfb_pkg;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_GLYPH = 3'd1,
      CMD_HLINE = 3'd2,
      CMD_VLINE = 3'd3,
      CMD_RECT  = 3'd4,
      CMD_FILL  = 3'd5,
      CMD_CLEAR = 3'd6,
      CMD_READ  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

   localparam int GLYPH_FIRST    = 32;
   localparam int GLYPH_LAST     = 126;
   localparam int GLYPH_COLS     = 5;
   localparam int GLYPH_ROWS     = 7;
   localparam int GLYPH_FALLBACK = 63;

   // One column of the 5x7 font: bit n is row n.
   function automatic logic [7:0] glyph_column(input logic [7:0] code_in,
                                               input logic [2:0] col_in);
      logic [7:0]  code_v;
      logic [39:0] row_v;
      code_v = (code_in < 8'(GLYPH_FIRST) || code_in > 8'(GLYPH_LAST)) ?
               8'(GLYPH_FALLBACK) : code_in;
      case (code_v)
         8'd32:  row_v = 40'h0000000000;
         8'd33:  row_v = 40'h00005F0000;
         8'd34:  row_v = 40'h0007000700;
         8'd35:  row_v = 40'h147F147F14;
         8'd36:  row_v = 40'h242A7F2A12;
         8'd37:  row_v = 40'h2313086462;
         8'd38:  row_v = 40'h3649552250;
         8'd39:  row_v = 40'h0005030000;
         8'd40:  row_v = 40'h001C224100;
         8'd41:  row_v = 40'h0041221C00;
         8'd42:  row_v = 40'h082A1C2A08;
         8'd43:  row_v = 40'h083E083E08;
         8'd44:  row_v = 40'h0050300000;
         8'd45:  row_v = 40'h0808080808;
         8'd46:  row_v = 40'h0060600000;
         8'd47:  row_v = 40'h2010080402;
         8'd48:  row_v = 40'h3E5149453E;
         8'd49:  row_v = 40'h00427F4000;
         8'd50:  row_v = 40'h4261514946;
         8'd51:  row_v = 40'h2141454B31;
         8'd52:  row_v = 40'h1814127F10;
         8'd53:  row_v = 40'h2745454539;
         8'd54:  row_v = 40'h3C4A494930;
         8'd55:  row_v = 40'h0171090503;
         8'd56:  row_v = 40'h3649494936;
         8'd57:  row_v = 40'h064949291E;
         8'd58:  row_v = 40'h0036360000;
         8'd59:  row_v = 40'h0056360000;
         8'd60:  row_v = 40'h0814224100;
         8'd61:  row_v = 40'h1414141414;
         8'd62:  row_v = 40'h0041221408;
         8'd63:  row_v = 40'h0201510906;
         8'd64:  row_v = 40'h324979413E;
         8'd65:  row_v = 40'h7E1111117E;
         8'd66:  row_v = 40'h7F49494936;
         8'd67:  row_v = 40'h3E41414122;
         8'd68:  row_v = 40'h7F4141221C;
         8'd69:  row_v = 40'h7F49494941;
         8'd70:  row_v = 40'h7F09090901;
         8'd71:  row_v = 40'h3E4149497A;
         8'd72:  row_v = 40'h7F0808087F;
         8'd73:  row_v = 40'h00417F4100;
         8'd74:  row_v = 40'h2040413F01;
         8'd75:  row_v = 40'h7F08142241;
         8'd76:  row_v = 40'h7F40404040;
         8'd77:  row_v = 40'h7F020C027F;
         8'd78:  row_v = 40'h7F0408107F;
         8'd79:  row_v = 40'h3E4141413E;
         8'd80:  row_v = 40'h7F09090906;
         8'd81:  row_v = 40'h3E4151215E;
         8'd82:  row_v = 40'h7F09192946;
         8'd83:  row_v = 40'h4649494931;
         8'd84:  row_v = 40'h01017F0101;
         8'd85:  row_v = 40'h3F4040403F;
         8'd86:  row_v = 40'h1F2040201F;
         8'd87:  row_v = 40'h3F4038403F;
         8'd88:  row_v = 40'h6314081463;
         8'd89:  row_v = 40'h0708700807;
         8'd90:  row_v = 40'h6151494543;
         8'd91:  row_v = 40'h007F414100;
         8'd92:  row_v = 40'h0204081020;
         8'd93:  row_v = 40'h0041417F00;
         8'd94:  row_v = 40'h0402010204;
         8'd95:  row_v = 40'h4040404040;
         8'd96:  row_v = 40'h0001020400;
         8'd97:  row_v = 40'h2054545478;
         8'd98:  row_v = 40'h7F48444438;
         8'd99:  row_v = 40'h3844444420;
         8'd100: row_v = 40'h384444487F;
         8'd101: row_v = 40'h3854545418;
         8'd102: row_v = 40'h087E090102;
         8'd103: row_v = 40'h0C5454543C;
         8'd104: row_v = 40'h7F08040478;
         8'd105: row_v = 40'h00447D4000;
         8'd106: row_v = 40'h2040443D00;
         8'd107: row_v = 40'h7F10284400;
         8'd108: row_v = 40'h00417F4000;
         8'd109: row_v = 40'h7C04180478;
         8'd110: row_v = 40'h7C08040478;
         8'd111: row_v = 40'h3844444438;
         8'd112: row_v = 40'h7C14141408;
         8'd113: row_v = 40'h081414187C;
         8'd114: row_v = 40'h7C08040408;
         8'd115: row_v = 40'h4854545420;
         8'd116: row_v = 40'h043F444020;
         8'd117: row_v = 40'h3C4040207C;
         8'd118: row_v = 40'h1C2040201C;
         8'd119: row_v = 40'h3C4030403C;
         8'd120: row_v = 40'h4428102844;
         8'd121: row_v = 40'h0C5050503C;
         8'd122: row_v = 40'h4464544C44;
         8'd123: row_v = 40'h0008364100;
         8'd124: row_v = 40'h00007F0000;
         8'd125: row_v = 40'h0041360800;
         8'd126: row_v = 40'h08082A1C08;
         default: row_v = 40'h0201510906;
      endcase
      case (col_in)
         3'd0:    glyph_column = row_v[39:32];
         3'd1:    glyph_column = row_v[31:24];
         3'd2:    glyph_column = row_v[23:16];
         3'd3:    glyph_column = row_v[15:8];
         default: glyph_column = row_v[7:0];
      endcase
   endfunction

endpackage

[sv/mono_page_framebuffer_draw_engine.sv]
// Top level: page-layout monochrome frame store with a pixel-serial draw sequencer.
// Each scanned pixel takes a SCAN step; a drawn one (on panel and, for a rectangle, on
// its border) then takes a WRITE step, while off-panel pixels and rectangle interiors
// are skipped. Clear writes one byte per step. One command at a time: busy is high
// until the cycle rsp_valid rises; the one-cycle result strobe cannot be stalled.
// Reset runs a clearing pass over all DEPTH store bytes (1024 by default) with busy held high.
module mono_page_framebuffer_draw_engine
   import mpfb_pkg::*;
#(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic signed [8:0] req_pos_x,
   input  logic signed [8:0] req_pos_y,
   input  logic [7:0] req_span_w,
   input  logic [7:0] req_span_h,
   input  logic [7:0] req_char_code,
   input  logic       req_color,
   input  logic [9:0] req_byte_index,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data
);

   localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
   localparam int DEPTH = PAGES * PANEL_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   // Frame store
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_ff;
   logic [AW-1:0] raddr, waddr;
   logic          wen;
   logic [7:0]    wdata;

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // Command registers
   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic signed [9:0] x0_ff, y0_ff;
   logic [7:0] w_ff, h_ff, code_ff;
   logic       color_ff;
   logic [9:0] bidx_ff;
   logic [7:0] i_ff, i_in, j_ff, j_in;
   logic [AW:0] clr_ff, clr_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0] bit_ff, bit_in;
   logic       on_ff, on_in;
   logic [7:0] out_ff, out_in;
   logic       vld_ff, vld_in;

   // Scan limits per command
   logic [7:0] lim_w, lim_h;
   always_comb begin
      case (cmd_ff)
         CMD_PIXEL: begin lim_w = 8'd1; lim_h = 8'd1; end
         CMD_GLYPH: begin lim_w = 8'(GLYPH_COLS); lim_h = 8'(GLYPH_ROWS); end
         CMD_HLINE: begin lim_w = w_ff; lim_h = 8'd1; end
         CMD_VLINE: begin lim_w = 8'd1; lim_h = h_ff; end
         default:   begin lim_w = w_ff; lim_h = h_ff; end
      endcase
   end

   // Current pixel and whether it is drawn
   logic signed [10:0] px, py;
   logic       inpan, member, dot, pix_on;
   logic [7:0] gcol;
   assign px = 11'(x0_ff) + 11'($signed({1'b0, i_ff}));
   assign py = 11'(y0_ff) + 11'($signed({1'b0, j_ff}));
   assign inpan = (px >= 0) && (px < 11'(PANEL_WIDTH)) &&
                  (py >= 0) && (py < 11'(PANEL_HEIGHT));
   assign gcol = glyph_column(code_ff, i_ff[2:0]);
   assign dot  = gcol[j_ff[2:0]];
   always_comb begin
      case (cmd_ff)
         CMD_RECT: member = (i_ff == 8'd0) || (j_ff == 8'd0) ||
                            (i_ff == w_ff - 8'd1) || (j_ff == h_ff - 8'd1);
         default:  member = 1'b1;
      endcase
      pix_on = (cmd_ff == CMD_GLYPH) ? (color_ff ? dot : !dot) : color_ff;
   end

   logic last_pix;
   assign last_pix = (i_ff == lim_w - 8'd1) && (j_ff == lim_h - 8'd1);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; clr_in = clr_ff;
      addr_in = addr_ff; bit_in = bit_ff; on_in = on_ff;
      out_in = out_ff; vld_in = 1'b0;
      raddr = addr_ff; waddr = clr_ff[AW-1:0]; wen = 1'b0; wdata = 8'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in = 8'd0; j_in = 8'd0; clr_in = '0; out_in = 8'd0;
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_SCAN;
               endcase
            end
         end
         ST_CLEAR: begin
            wen = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (lim_w == 8'd0 || lim_h == 8'd0) begin
               state_in = ST_DONE;
            end else begin
               addr_in = AW'(32'(py[9:3]) * PANEL_WIDTH + 32'(px[9:0]));
               bit_in  = py[2:0];
               on_in   = pix_on;
               raddr   = addr_in;
               if (inpan && member) state_in = ST_WRITE;
               else if (last_pix) state_in = ST_DONE;
               if (j_ff == lim_h - 8'd1) begin
                  j_in = 8'd0; i_in = i_ff + 8'd1;
               end else begin
                  j_in = j_ff + 8'd1;
               end
            end
         end
         ST_WRITE: begin
            wen   = 1'b1;
            waddr = addr_ff;
            wdata = rd_ff;
            wdata[bit_ff] = on_ff;
            state_in = (i_ff == lim_w) ? ST_DONE : ST_SCAN;
         end
         ST_READ: begin
            raddr = AW'(bidx_ff);
            state_in = ST_DONE;
            if (32'(bidx_ff) < DEPTH) state_in = ST_WRITE;
         end
         ST_DONE: begin
            vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // Read command reuses the WRITE slot only to capture data
      if (state_ff == ST_WRITE && cmd_ff == CMD_READ) begin
         wen = 1'b0;
         out_in = rd_ff;
         state_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
         cmd_ff   <= CMD_CLEAR;
      end else begin
         state_ff <= (state_ff == ST_CLEAR && cmd_ff == CMD_CLEAR && state_in == ST_DONE &&
                      vld_ff == 1'b0 && out_ff == 8'hFF) ? ST_IDLE : state_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
         if (state_ff == ST_IDLE && start) cmd_ff <= cmd_type'(req_cmd);
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in;
      addr_ff <= addr_in; bit_ff <= bit_in; on_ff <= on_in;
      out_ff <= reset ? 8'hFF : out_in;
      if (state_ff == ST_IDLE && start) begin
         x0_ff <= 10'(req_pos_x); y0_ff <= 10'(req_pos_y);
         w_ff <= req_span_w; h_ff <= req_span_h;
         code_ff <= req_char_code; color_ff <= req_color;
         bidx_ff <= req_byte_index;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = vld_ff;
   assign rsp_read_data = out_ff;

   // Checks
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result without return to idle");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cmd_ff != CMD_READ) |-> rsp_read_data == 8'd0)
      else $error("nonzero data for drawing command");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the page framebuffer draw engine: directed table plus random commands.
module testbench
   import mpfb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PANEL_W     = 128;
   localparam int PANEL_H     = 64;
   localparam int STORE_BYTES = ((PANEL_H + 7) / 8) * PANEL_W;
   localparam int RANDOM_ITEMS = 1625;
   localparam int CALM_ITEMS   = 200;

   // 5x7 font, columns 0..4 from the top byte down, bit n of a column is row n
   localparam logic [39:0] FONT_COLS [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h083E083E08, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

   typedef struct {
      cmd_type           op;
      logic signed [8:0] x;
      logic signed [8:0] y;
      logic [7:0]        w;
      logic [7:0]        h;
      logic [7:0]        code;
      logic              color;
      logic [9:0]        index;
      logic              fixed;   // read_data below is known by hand
      logic [7:0]        fixed_data;
   } draw_cmd_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_cmd = '0;
   logic signed [8:0] req_pos_x = '0;
   logic signed [8:0] req_pos_y = '0;
   logic [7:0]        req_span_w = '0;
   logic [7:0]        req_span_h = '0;
   logic [7:0]        req_char_code = '0;
   logic              req_color = 1'b0;
   logic [9:0]        req_byte_index = '0;
   logic              rsp_valid;
   logic [7:0]        rsp_read_data;

   logic [7:0] shadow_store [STORE_BYTES];
   logic [7:0] pending_bytes [$];
   int         error_count = 0;
   int         result_count = 0;
   int         op_count [8];

   mono_page_framebuffer_draw_engine dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100ms;
      $display("timeout at %0t, %0d results still pending", $realtime, pending_bytes.size());
      $display("status: fail");
      $finish;
   end

   // Shadow frame store update for one pixel
   function automatic void paint_pixel(int px, int py, bit on);
      int idx;
      if (px < 0 || px >= PANEL_W || py < 0 || py >= PANEL_H) return;
      idx = (py / 8) * PANEL_W + px;
      if (on) shadow_store[idx][py % 8] = 1'b1;
      else    shadow_store[idx][py % 8] = 1'b0;
   endfunction

   function automatic void paint_area(int px, int py, int aw, int ah, bit on);
      for (int i = 0; i < aw; i++)
         for (int j = 0; j < ah; j++)
            paint_pixel(px + i, py + j, on);
   endfunction

   // Applies one command to the shadow store; returns the byte it reads back
   function automatic logic [7:0] run_draw_command(draw_cmd_type c);
      int         px, py, aw, ah, g;
      logic [7:0] col_bits;
      logic [7:0] rd;
      px = c.x;
      py = c.y;
      aw = c.w;
      ah = c.h;
      rd = '0;
      case (c.op)
         CMD_PIXEL: paint_pixel(px, py, c.color);
         CMD_GLYPH: begin
            g = (c.code < GLYPH_FIRST || c.code > GLYPH_LAST) ? GLYPH_FALLBACK : c.code;
            for (int col = 0; col < GLYPH_COLS; col++) begin
               col_bits = FONT_COLS[g - GLYPH_FIRST][39 - 8 * col -: 8];
               for (int row = 0; row < GLYPH_ROWS; row++)
                  paint_pixel(px + col, py + row, c.color ? col_bits[row] : !col_bits[row]);
            end
         end
         CMD_HLINE: paint_area(px, py, aw, 1, c.color);
         CMD_VLINE: paint_area(px, py, 1, ah, c.color);
         CMD_RECT: begin
            if (aw > 0 && ah > 0) begin
               paint_area(px, py, aw, 1, c.color);
               paint_area(px, py + ah - 1, aw, 1, c.color);
               paint_area(px, py, 1, ah, c.color);
               paint_area(px + aw - 1, py, 1, ah, c.color);
            end
         end
         CMD_FILL:  paint_area(px, py, aw, ah, c.color);
         CMD_CLEAR: foreach (shadow_store[i]) shadow_store[i] = '0;
         default:   if (c.index < STORE_BYTES) rd = shadow_store[c.index];
      endcase
      return rd;
   endfunction

   // Drive one command and hold it until the engine takes the transfer
   task automatic issue_command(draw_cmd_type c);
      logic [7:0] want;
      req_cmd        <= c.op;
      req_pos_x      <= c.x;
      req_pos_y      <= c.y;
      req_span_w     <= c.w;
      req_span_h     <= c.h;
      req_char_code  <= c.code;
      req_color      <= c.color;
      req_byte_index <= c.index;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      want = run_draw_command(c);
      pending_bytes.push_back(c.fixed ? c.fixed_data : want);
      op_count[c.op]++;
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic draw_cmd_type make_row(cmd_type op, int x, int y, int w, int h,
                                             int code, bit color, int index,
                                             bit fixed = 0, int fixed_data = 0);
      draw_cmd_type c;
      c.op = op;
      c.x = 9'(x);
      c.y = 9'(y);
      c.w = 8'(w);
      c.h = 8'(h);
      c.code = 8'(code);
      c.color = color;
      c.index = 10'(index);
      c.fixed = fixed;
      c.fixed_data = 8'(fixed_data);
      return c;
   endfunction

   // Random command: mostly on or near the panel, small shapes, some long thin ones
   function automatic draw_cmd_type random_command();
      draw_cmd_type c;
      int           pick, shape;
      pick = $urandom_range(0, 99);
      if      (pick < 15) c.op = CMD_PIXEL;
      else if (pick < 35) c.op = CMD_GLYPH;
      else if (pick < 43) c.op = CMD_HLINE;
      else if (pick < 51) c.op = CMD_VLINE;
      else if (pick < 59) c.op = CMD_RECT;
      else if (pick < 68) c.op = CMD_FILL;
      else if (pick < 70) c.op = CMD_CLEAR;
      else                c.op = CMD_READ;
      if ($urandom_range(0, 9) == 0) begin
         c.x = 9'($urandom);
         c.y = 9'($urandom);
      end else begin
         c.x = 9'($urandom_range(0, PANEL_W + 15) - 8);
         c.y = 9'($urandom_range(0, PANEL_H + 15) - 8);
      end
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         c.w = 8'($urandom_range(0, 255));
         c.h = 8'($urandom_range(0, 2));
      end else if (shape == 1) begin
         c.w = 8'($urandom_range(0, 2));
         c.h = 8'($urandom_range(0, 255));
      end else begin
         c.w = 8'($urandom_range(0, 10));
         c.h = 8'($urandom_range(0, 10));
      end
      c.code = 8'($urandom);
      c.color = ($urandom_range(0, 3) != 0);
      c.index = 10'($urandom_range(0, STORE_BYTES - 1));
      c.fixed = 1'b0;
      c.fixed_data = '0;
      return c;
   endfunction

   // Result checker: every strobe pops the oldest expected byte
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (pending_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, read_data %02h", $realtime, rsp_read_data);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_read_data !== want) begin
               error_count++;
               $display("%0t: read_data mismatch, expected %02h, actual %02h",
                        $realtime, want, rsp_read_data);
            end
         end
      end
   end

   // Stimulus
   initial begin
      draw_cmd_type directed [$];
      int           wait_cycles;
      foreach (shadow_store[i]) shadow_store[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;

      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1, 8'h00));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 1023, 1, 8'h00));
      directed.push_back(make_row(CMD_PIXEL, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 0, 1, 8'h01));
      directed.push_back(make_row(CMD_PIXEL, 127, 63, 255, 255, 255, 1, 1023));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 1023, 1, 8'h80));
      // off-panel pixels are dropped
      directed.push_back(make_row(CMD_PIXEL, -256, 255, 0, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_PIXEL, 255, -1, 0, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_PIXEL, 128, 64, 0, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_GLYPH, 0, 8, 0, 0, 65, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 128, 1, 8'h7E));
      // codes outside the font draw a question mark
      directed.push_back(make_row(CMD_GLYPH, 10, 8, 0, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 140, 1, 8'h51));
      // inverted glyph leaves the eighth cell row alone
      directed.push_back(make_row(CMD_GLYPH, 20, 8, 0, 0, 255, 0, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 148, 1, 8'h7D));
      directed.push_back(make_row(CMD_GLYPH, 124, 60, 0, 0, 126, 1, 0));
      directed.push_back(make_row(CMD_GLYPH, -3, -4, 0, 0, 32, 0, 0));
      directed.push_back(make_row(CMD_HLINE, -100, 16, 255, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 261, 1, 8'h01));
      directed.push_back(make_row(CMD_VLINE, 3, -100, 0, 255, 0, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 3, 1, 8'hFF));
      directed.push_back(make_row(CMD_RECT,  -10, 40, 255, 2, 0, 1, 0));
      // zero sizes draw nothing
      directed.push_back(make_row(CMD_RECT,  5, 5, 5, 0, 0, 1, 0));
      directed.push_back(make_row(CMD_FILL,  5, 5, 0, 5, 0, 1, 0));
      directed.push_back(make_row(CMD_FILL,  0, 0, 128, 64, 0, 1, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 500, 1, 8'hFF));
      directed.push_back(make_row(CMD_FILL,  4, 4, 3, 3, 0, 0, 0));
      directed.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_row(CMD_READ,  0, 0, 0, 0, 0, 0, 500, 1, 8'h00));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         issue_command(directed[i]);
         if ($urandom_range(0, 2) == 0) sender_gap();
      end
      start <= 1'b0;

      // hold off until the directed part has fully drained
      wait_cycles = 0;
      while (pending_bytes.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         issue_command(random_command());
         if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) sender_gap();
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_bytes.size() != 0 && wait_cycles < 400000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);

      if (pending_bytes.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $realtime, pending_bytes.size());
      end
      $display("covered %0d results: pixel %0d, glyph %0d, hline %0d, vline %0d",
               result_count, op_count[CMD_PIXEL], op_count[CMD_GLYPH],
               op_count[CMD_HLINE], op_count[CMD_VLINE]);
      $display("rect %0d, fill %0d, clear %0d, read %0d; %0d errors",
               op_count[CMD_RECT], op_count[CMD_FILL], op_count[CMD_CLEAR],
               op_count[CMD_READ], error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
